// File: design/msm_pkg.sv
// Shared types and constants for the multivoice sample mixer.
package msm_pkg;

   localparam logic [2:0] OP_LOAD   = 3'd0;
   localparam logic [2:0] OP_START  = 3'd1;
   localparam logic [2:0] OP_PAN    = 3'd2;
   localparam logic [2:0] OP_STOP   = 3'd3;
   localparam logic [2:0] OP_RENDER = 3'd4;

   localparam logic CSR_OUTPUT_RATE = 1'b0;
   localparam logic CSR_VOICES      = 1'b1;

   localparam logic [19:0] OUTPUT_RATE_RESET = 20'd48000;
   localparam logic [4:0]  VOICES_RESET      = 5'd16;
   localparam int          CSR_DATA_W        = 20;

   typedef struct packed {
      logic [2:0]  op;
      logic [3:0]  voice;
      logic [15:0] address;
      logic [7:0]  sample_byte;
      logic [16:0] length;
      logic [19:0] source_rate_hz;
      logic [31:0] pitch_mult;
      logic [7:0]  volume;
      logic [8:0]  separation;
   } req_type;

   typedef struct packed {
      logic signed [15:0] left_out;
      logic signed [15:0] right_out;
      logic               error;
      logic [15:0]        active_mask;
   } rsp_type;

   // Classified request handed from front to back.
   typedef struct packed {
      logic [2:0]  op;
      logic        valid_voice;
      logic        bad_start;
      logic [3:0]  voice;
      logic [15:0] address;
      logic [7:0]  sample_byte;
      logic [16:0] length;
      logic [19:0] source_rate_hz;
      logic [31:0] pitch_mult;
      logic [6:0]  volume;
      logic [7:0]  separation;
   } cmd_type;

endpackage

// File: design/multivoice_sample_mixer_top.sv
// Top level of the multivoice sample mixer.
//  channel | ports                          | direction
//  req     | req_push req_full req_data     | in
//  rsp     | rsp_empty rsp_pop rsp_data     | out
//  csr     | csr_wr_en csr_index csr_data   | in
// Load, stop, unknown and errored requests answer straight from the idle state;
// pan goes through the gain states; start also runs the step divider, which yields one quotient bit a cycle.
// Render steps through the voices in turn and, for each active voice, uses the shared
// multiplier and the sample memory read port.
// Reset is synchronous; sample memory is not cleared. The back end takes no new
// request until its result is popped; a front register holds one meanwhile.
module multivoice_sample_mixer_top import msm_pkg::*; #(
   parameter int MAX_VOICES = 16,
   parameter int SAMPLE_MEM_DEPTH = 65536
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  req_type               req_data,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);
   logic [19:0] rate_ff;
   logic [4:0]  voices_ff;
   logic        cmd_valid, cmd_ready;
   cmd_type     cmd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff   <= OUTPUT_RATE_RESET;
         voices_ff <= VOICES_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_OUTPUT_RATE: rate_ff   <= csr_data;
            CSR_VOICES:      voices_ff <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   msm_front #(.MAX_VOICES(MAX_VOICES)) u_front (
      .clock(clock), .reset(reset), .push(req_push), .full(req_full),
      .req_data(req_data), .output_rate_hz(rate_ff), .voices_in_use(voices_ff),
      .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_data(cmd_data));

   msm_back #(.MAX_VOICES(MAX_VOICES), .SAMPLE_MEM_DEPTH(SAMPLE_MEM_DEPTH)) u_back (
      .clock(clock), .reset(reset), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
      .cmd_data(cmd_data), .output_rate_hz(rate_ff), .voices_in_use(voices_ff),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data));
endmodule

// File: design/msm_ram.sv
// Generic single-port RAM with registered read.
module msm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[addr] <= wr_data;
      rd_ff <= mem_ff[addr];
   end

   assign rd_data = rd_ff;
endmodule

// File: design/msm_front.sv
// Front end: checks voice index and start parameters, clamps gains inputs.
module msm_front import msm_pkg::*; #(
   parameter int MAX_VOICES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  req_type     req_data,
   input  logic [19:0] output_rate_hz,
   input  logic [4:0]  voices_in_use,
   output logic        cmd_valid,
   input  logic        cmd_ready,
   output cmd_type     cmd_data
);
   localparam logic [6:0] MaxV = 7'(MAX_VOICES);
   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   logic [6:0] count;

   assign count = ({2'b0, voices_in_use} > MaxV) ? MaxV : {2'b0, voices_in_use};
   assign full  = valid_ff && !cmd_ready;

   always_comb begin
      cmd_in = cmd_ff;
      valid_in = valid_ff && !cmd_ready;
      if (push && !full) begin
         valid_in              = 1'b1;
         cmd_in.op             = req_data.op;
         cmd_in.voice          = req_data.voice;
         cmd_in.valid_voice    = {3'b0, req_data.voice} < count;
         cmd_in.bad_start      = req_data.length == '0 || req_data.source_rate_hz == '0
                                 || req_data.pitch_mult == '0 || output_rate_hz == '0;
         cmd_in.address        = req_data.address;
         cmd_in.sample_byte    = req_data.sample_byte;
         cmd_in.length         = req_data.length[16] ? 17'h10000 : req_data.length;
         cmd_in.source_rate_hz = req_data.source_rate_hz;
         cmd_in.pitch_mult     = req_data.pitch_mult;
         cmd_in.volume         = req_data.volume > 8'd127 ? 7'd127 : req_data.volume[6:0];
         cmd_in.separation     = req_data.separation > 9'd254 ? 8'd254
                                 : req_data.separation[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      cmd_ff <= cmd_in;
   end

   assign cmd_valid = valid_ff;
   assign cmd_data  = cmd_ff;
endmodule

// File: design/msm_back.sv
// Back end: voice state, divider, render loop with one shared multiplier.
module msm_back import msm_pkg::*; #(
   parameter int MAX_VOICES = 16,
   parameter int SAMPLE_MEM_DEPTH = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   output logic        cmd_ready,
   input  cmd_type     cmd_data,
   input  logic [19:0] output_rate_hz,
   input  logic [4:0]  voices_in_use,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_data
);
   localparam int VW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
   localparam int AW = $clog2(SAMPLE_MEM_DEPTH);
   localparam int CW = VW + 1;
   localparam logic [6:0] MaxV = 7'(MAX_VOICES);

   localparam logic [3:0] S_IDLE = 4'd0, S_DIV = 4'd1, S_GAIN = 4'd2,
      S_RCHK = 4'd3, S_RWAIT = 4'd4, S_RMUL_L = 4'd5, S_RMUL_R = 4'd6,
      S_RDIV = 4'd7, S_RADV = 4'd8, S_DONE = 4'd9, S_GAIN2 = 4'd10;

   logic [3:0] state_ff, state_in;
   logic [MAX_VOICES-1:0] act_ff, act_in;
   logic [15:0] base_ff [MAX_VOICES];
   logic [16:0] len_ff  [MAX_VOICES];
   logic [32:0] pos_ff  [MAX_VOICES];
   logic [31:0] step_ff [MAX_VOICES];
   logic [6:0]  lg_ff   [MAX_VOICES];
   logic [6:0]  rg_ff   [MAX_VOICES];

   cmd_type     cur_ff;      // request being worked on
   logic [19:0] rate_ff;     // latched divisor
   logic [51:0] rem_ff;      // dividend shift register / quotient
   logic [20:0] part_ff;     // partial remainder
   logic [5:0]  cnt_ff;
   logic [CW-1:0] vi_ff;
   logic signed [31:0] sl_ff, sr_ff;
   logic signed [31:0] prod_ff;
   logic [6:0]  ga_ff;
   logic [7:0]  gb_ff;
   logic [15:0] gprod_ff;
   logic out_valid_ff;
   rsp_type out_ff;
   logic err_ff;

   // multiply srate*pitch: 20x32, latched into rem_ff when a request is taken in idle
   logic [51:0] dividend;
   assign dividend = {32'b0, cmd_data.source_rate_hz} * {20'b0, cmd_data.pitch_mult};

   logic [6:0] count;
   assign count = ({2'b0, voices_in_use} > MaxV) ? MaxV : {2'b0, voices_in_use};

   // sample memory
   logic          mem_we;
   logic [AW-1:0] mem_addr;
   logic [7:0]    mem_rd;
   logic [VW-1:0] vi;
   assign vi = vi_ff[VW-1:0];
   logic [16:0] idx;
   assign idx = pos_ff[vi][32:16];
   logic [AW-1:0] rd_addr;
   assign rd_addr = AW'({1'b0, base_ff[vi]} + idx);

   assign mem_we   = state_ff == S_IDLE && cmd_valid && !out_valid_ff
                     && cmd_data.op == OP_LOAD;
   assign mem_addr = mem_we ? AW'(cmd_data.address) : rd_addr;

   msm_ram #(.WIDTH(8), .DEPTH(SAMPLE_MEM_DEPTH)) u_mem (
      .clock(clock), .wr_en(mem_we), .addr(mem_addr),
      .wr_data(cmd_data.sample_byte), .rd_data(mem_rd));

   // divide by 127 for signed product, truncate toward zero
   function automatic logic signed [31:0] div127(input logic signed [31:0] x);
      logic [31:0] a;
      logic [47:0] q;
      logic [31:0] r;
      a = x[31] ? 32'(-x) : 32'(x);
      q = ({16'b0, a} * 48'd33026) >> 22;
      r = 32'(q);
      if (a - r * 32'd127 >= 32'd127) r = r + 32'd1;
      return x[31] ? -$signed(r) : $signed(r);
   endfunction

   // divide 0..32258 by 254
   function automatic logic [6:0] div254(input logic [15:0] x);
      logic [31:0] q;
      logic [6:0] r;
      q = ({16'b0, x} * 32'd16513) >> 22;
      r = q[6:0];
      if (x - 16'(r) * 16'd254 >= 16'd254) r = r + 7'd1;
      return r;
   endfunction

   logic [20:0] trial;
   assign trial = {part_ff[19:0], rem_ff[51]} - {1'b0, rate_ff};

   logic doing_render;
   assign doing_render = state_ff != S_IDLE;
   assign cmd_ready = state_ff == S_IDLE && !out_valid_ff;

   logic [CW-1:0] vi_next;
   assign vi_next = vi_ff + CW'(1);
   logic signed [15:0] smp;
   assign smp = $signed({1'b0, mem_rd} - 9'd128) * 16'sd256;
   logic [32:0] newpos;
   assign newpos = pos_ff[vi] + {1'b0, step_ff[vi]};

   always_comb begin
      state_in = state_ff;
      act_in   = act_ff;
      unique case (state_ff)
         S_IDLE: if (cmd_valid && cmd_ready) begin
            priority if (cmd_data.op == OP_START) begin
               if (cmd_data.valid_voice && !cmd_data.bad_start) state_in = S_DIV;
            end else if (cmd_data.op == OP_PAN) begin
               if (cmd_data.valid_voice) state_in = S_GAIN;
            end else if (cmd_data.op == OP_STOP) begin
               if (cmd_data.valid_voice) act_in[cmd_data.voice[VW-1:0]] = 1'b0;
            end else if (cmd_data.op == OP_RENDER) begin
               state_in = S_RCHK;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DIV:  if (cnt_ff == 6'd51) state_in = S_GAIN;
         S_GAIN: state_in = S_GAIN2;
         S_GAIN2: begin
            if (cur_ff.op == OP_START) act_in[cur_ff.voice[VW-1:0]] = 1'b1;
            state_in = S_DONE;
         end
         S_RCHK: begin
            if ({{(7-CW){1'b0}}, vi_ff} >= count) state_in = S_DONE;
            else if (!act_ff[vi]) state_in = S_RCHK;
            else if (idx >= len_ff[vi]) begin
               act_in[vi] = 1'b0;
               state_in = S_RCHK;
            end else state_in = S_RWAIT;
         end
         S_RWAIT:  state_in = S_RMUL_L;
         S_RMUL_L: state_in = S_RMUL_R;
         S_RMUL_R: state_in = S_RDIV;
         S_RDIV:   state_in = S_RADV;
         S_RADV: begin
            if (newpos[32:16] >= len_ff[vi]) act_in[vi] = 1'b0;
            state_in = S_RCHK;
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         act_ff       <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_VOICES; i++) begin
            base_ff[i] <= '0; len_ff[i] <= '0; pos_ff[i] <= '0;
            step_ff[i] <= '0; lg_ff[i] <= '0; rg_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         act_ff   <= act_in;
         if (out_valid_ff && rsp_pop) out_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (cmd_valid && cmd_ready) begin
               cur_ff  <= cmd_data;
               vi_ff   <= '0;
               sl_ff   <= '0;
               sr_ff   <= '0;
               err_ff  <= 1'b0;
               rate_ff <= output_rate_hz;
               rem_ff  <= dividend;
               part_ff <= '0;
               cnt_ff  <= '0;
               ga_ff   <= cmd_data.volume;
               gb_ff   <= 8'd254 - cmd_data.separation;
               if ((cmd_data.op == OP_START || cmd_data.op == OP_PAN ||
                    cmd_data.op == OP_STOP) && !cmd_data.valid_voice)
                  err_ff <= 1'b1;
               if (cmd_data.op == OP_START && cmd_data.bad_start) err_ff <= 1'b1;
               if (cmd_data.op == OP_STOP && cmd_data.valid_voice) begin
                  base_ff[cmd_data.voice[VW-1:0]] <= '0;
                  len_ff[cmd_data.voice[VW-1:0]]  <= '0;
                  pos_ff[cmd_data.voice[VW-1:0]]  <= '0;
                  step_ff[cmd_data.voice[VW-1:0]] <= '0;
                  lg_ff[cmd_data.voice[VW-1:0]]   <= '0;
                  rg_ff[cmd_data.voice[VW-1:0]]   <= '0;
               end
               // ops that finish here answer at once
               if (!(cmd_data.op == OP_RENDER ||
                     (cmd_data.op == OP_START && cmd_data.valid_voice
                      && !cmd_data.bad_start) ||
                     (cmd_data.op == OP_PAN && cmd_data.valid_voice))) begin
                  out_valid_ff      <= 1'b1;
                  out_ff.left_out   <= '0;
                  out_ff.right_out  <= '0;
                  out_ff.error      <= (cmd_data.op == OP_START || cmd_data.op == OP_PAN
                                        || cmd_data.op == OP_STOP)
                                       && (!cmd_data.valid_voice
                                           || (cmd_data.op == OP_START
                                               && cmd_data.bad_start));
                  out_ff.active_mask <= 16'(act_in) & 16'(((64'd1 << count) - 64'd1));
               end
            end
            S_DIV: begin
               // restoring division, one quotient bit per cycle
               if (!trial[20]) part_ff <= trial;
               else part_ff <= {part_ff[19:0], rem_ff[51]};
               rem_ff <= {rem_ff[50:0], !trial[20]};
               cnt_ff <= cnt_ff + 6'd1;
            end
            S_GAIN: begin
               // left gain product = vol*(254-sep)
               gprod_ff <= 16'(ga_ff) * 16'(gb_ff);
               if (cur_ff.op == OP_START) begin
                  base_ff[cur_ff.voice[VW-1:0]] <= cur_ff.address;
                  len_ff[cur_ff.voice[VW-1:0]]  <= cur_ff.length;
                  pos_ff[cur_ff.voice[VW-1:0]]  <= '0;
                  step_ff[cur_ff.voice[VW-1:0]] <= (rem_ff[51:32] != '0) ? '1
                     : (rem_ff[31:0] == '0) ? 32'd1 : rem_ff[31:0];
               end
            end
            S_GAIN2: begin
               lg_ff[cur_ff.voice[VW-1:0]] <= div254(gprod_ff);
               rg_ff[cur_ff.voice[VW-1:0]] <=
                  div254(16'(cur_ff.volume) * 16'(cur_ff.separation));
            end
            S_RCHK: if (state_in != S_RWAIT && state_in != S_DONE) vi_ff <= vi_next;
            S_RWAIT: ;
            S_RMUL_L: prod_ff <= 32'(smp) * $signed({25'b0, lg_ff[vi]});
            S_RMUL_R: begin
               sl_ff   <= sl_ff + div127(prod_ff);
               prod_ff <= 32'(smp) * $signed({25'b0, rg_ff[vi]});
            end
            S_RDIV: sr_ff <= sr_ff + div127(prod_ff);
            S_RADV: begin
               pos_ff[vi] <= newpos;
               vi_ff <= vi_next;
            end
            S_DONE: begin
               out_valid_ff <= 1'b1;
               out_ff.left_out  <= (sl_ff < -32768) ? -16'sd32768
                                   : (sl_ff > 32767) ? 16'sd32767 : sl_ff[15:0];
               out_ff.right_out <= (sr_ff < -32768) ? -16'sd32768
                                   : (sr_ff > 32767) ? 16'sd32767 : sr_ff[15:0];
               out_ff.error     <= err_ff;
               out_ff.active_mask <= 16'(act_ff) & 16'(((64'd1 << count) - 64'd1));
            end
            default: ;
         endcase
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   a_busy_no_take: assert property (@(posedge clock) disable iff (reset)
      doing_render |-> !cmd_ready) else $error("command taken while busy");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_pop) |=> out_valid_ff) else $error("result lost");
   a_done_out: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE |=> out_valid_ff) else $error("no result after finish");
endmodule

// File: test/testbench.sv
// Self-checking testbench for the multivoice sample mixer top level.
module testbench;
   import msm_pkg::*;

   localparam int VOICE_CNT = 16;
   localparam int MEM_DEPTH = 65536;
   localparam int CYCLE_LIMIT = 1500000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   req_type req_data = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic csr_index = CSR_OUTPUT_RATE;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   multivoice_sample_mixer_top u_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mixer shadow state
   logic [7:0]  mix_mem [MEM_DEPTH];
   logic        v_active [VOICE_CNT];
   logic [15:0] v_base [VOICE_CNT];
   logic [16:0] v_len [VOICE_CNT];
   logic [32:0] v_pos [VOICE_CNT];
   logic [31:0] v_step [VOICE_CNT];
   int          v_lgain [VOICE_CNT];
   int          v_rgain [VOICE_CNT];
   logic [19:0] out_rate;
   logic [4:0]  voice_limit;

   rsp_type frames_due [$];
   int errors = 0;
   int accepted = 0;
   int responses = 0;
   int renders = 0;
   longint cycles = 0;
   int send_idle_pct = 19;
   int recv_idle_pct = 75;
   bit recv_hold = 1'b0;

   function automatic void set_gains(int v, logic [7:0] vol_in, logic [8:0] sep_in);
      int vol, sep;
      vol = (vol_in > 127) ? 127 : vol_in;
      sep = (sep_in > 254) ? 254 : sep_in;
      v_lgain[v] = (vol * (254 - sep)) / 254;
      v_rgain[v] = (vol * sep) / 254;
   endfunction

   function automatic int sat16(int x);
      if (x < -32768) return -32768;
      if (x > 32767) return 32767;
      return x;
   endfunction

   function automatic rsp_type mix_step(req_type r);
      rsp_type o;
      int cnt, sl, sr, s, ls, rs;
      bit ok;
      logic [63:0] st;
      logic [32:0] idx;
      o = '0;
      cnt = (voice_limit > VOICE_CNT) ? VOICE_CNT : voice_limit;
      ok = r.voice < cnt;
      case (r.op)
         OP_LOAD: begin
            mix_mem[r.address] = r.sample_byte;
         end
         OP_START: begin
            if (!ok || r.length == 0 || r.source_rate_hz == 0 || r.pitch_mult == 0
                || out_rate == 0) o.error = 1'b1;
            else begin
               st = (64'(r.source_rate_hz) * 64'(r.pitch_mult)) / 64'(out_rate);
               if (st > 64'hFFFF_FFFF) st = 64'hFFFF_FFFF;
               if (st == 0) st = 64'd1;
               v_base[r.voice] = r.address;
               v_len[r.voice] = (r.length > 65536) ? 17'd65536 : r.length;
               v_pos[r.voice] = '0;
               v_step[r.voice] = st[31:0];
               set_gains(r.voice, r.volume, r.separation);
               v_active[r.voice] = 1'b1;
            end
         end
         OP_PAN: begin
            if (!ok) o.error = 1'b1;
            else set_gains(r.voice, r.volume, r.separation);
         end
         OP_STOP: begin
            if (!ok) o.error = 1'b1;
            else begin
               v_active[r.voice] = 1'b0; v_base[r.voice] = '0; v_len[r.voice] = '0;
               v_pos[r.voice] = '0; v_step[r.voice] = '0;
               v_lgain[r.voice] = 0; v_rgain[r.voice] = 0;
            end
         end
         OP_RENDER: begin
            sl = 0; sr = 0;
            for (int i = 0; i < cnt; i++) begin
               if (!v_active[i]) continue;
               idx = v_pos[i] >> 16;
               if (idx >= v_len[i]) begin
                  v_active[i] = 1'b0;
                  continue;
               end
               s = (int'(mix_mem[16'(v_base[i] + idx[15:0])]) - 128) * 256;
               ls = (s * v_lgain[i]) / 127;
               rs = (s * v_rgain[i]) / 127;
               sl += ls; sr += rs;
               v_pos[i] = v_pos[i] + v_step[i];
               if ((v_pos[i] >> 16) >= v_len[i]) v_active[i] = 1'b0;
            end
            o.left_out = 16'(sat16(sl));
            o.right_out = 16'(sat16(sr));
         end
         default: ;
      endcase
      for (int i = 0; i < cnt; i++) o.active_mask[i] = v_active[i];
      return o;
   endfunction

   // request is taken at the first edge whose preceding half cycle shows full low
   task automatic send_request(req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= r;
      @(negedge clock);
      while (req_full) @(negedge clock);
      @(posedge clock);
      frames_due.push_back(mix_step(r));
      accepted++;
      if (r.op == OP_RENDER) renders++;
   endtask

   // wait until every expected result has been popped, then give slack
   task automatic drain();
      int n;
      n = 0;
      req_push <= 1'b0;
      while (frames_due.size() != 0) @(posedge clock);
      while (n < 200) begin
         @(posedge clock);
         n++;
      end
   endtask

   task automatic write_csr(logic idx, logic [CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_OUTPUT_RATE) out_rate = val;
      else voice_limit = val[4:0];
      @(posedge clock);
   endtask

   // receiver
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         responses++;
         if (frames_due.size() == 0) begin
            $display("%0t: unexpected response %p", $time, rsp_data);
            errors++;
         end else begin
            rsp_type e;
            e = frames_due.pop_front();
            if (rsp_data.left_out !== e.left_out) begin
               $display("%0t: left_out exp %0d got %0d", $time, e.left_out, rsp_data.left_out);
               errors++;
            end
            if (rsp_data.right_out !== e.right_out) begin
               $display("%0t: right_out exp %0d got %0d", $time, e.right_out,
                        rsp_data.right_out);
               errors++;
            end
            if (rsp_data.error !== e.error) begin
               $display("%0t: error exp %0b got %0b", $time, e.error, rsp_data.error);
               errors++;
            end
            if (rsp_data.active_mask !== e.active_mask) begin
               $display("%0t: active_mask exp %h got %h", $time, e.active_mask,
                        rsp_data.active_mask);
               errors++;
            end
         end
      end
      rsp_pop <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic req_type rand_req();
      req_type r;
      r = '0;
      r.op = 3'($urandom_range(7));
      r.voice = 4'($urandom_range(15));
      r.address = 16'($urandom);
      r.sample_byte = 8'($urandom);
      r.length = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(40));
      r.source_rate_hz = ($urandom_range(19) == 0) ? 20'd0 : 20'($urandom);
      r.pitch_mult = ($urandom_range(19) == 0) ? 32'd0 : $urandom;
      r.volume = 8'($urandom);
      r.separation = 9'($urandom);
      return r;
   endfunction

   // start only over written memory: base in the preloaded window
   function automatic req_type start_req(int v);
      req_type r;
      r = rand_req();
      r.op = OP_START;
      r.voice = 4'(v);
      r.address = 16'($urandom_range(255));
      r.length = 17'($urandom_range(1, 64));
      r.source_rate_hz = 20'($urandom_range(8000, 96000));
      r.pitch_mult = $urandom_range(32'h8000, 32'h30000);
      return r;
   endfunction

   // directed rows: op voice addr byte len srate pitch vol sep, then expected
   typedef struct {
      req_type r;
      bit      typed;
      rsp_type e;
   } row_type;

   function automatic row_type mk(logic [2:0] op, logic [3:0] v, logic [15:0] a,
                                  logic [7:0] b, logic [16:0] l, logic [19:0] s,
                                  logic [31:0] p, logic [7:0] vol, logic [8:0] sep,
                                  bit typed, logic err, logic [15:0] m);
      row_type t;
      t.r = '{op, v, a, b, l, s, p, vol, sep};
      t.typed = typed;
      t.e = '{16'sd0, 16'sd0, err, m};
      return t;
   endfunction

   initial begin
      row_type rows [$];
      req_type r;
      int guard;

      for (int i = 0; i < VOICE_CNT; i++) begin
         v_active[i] = 1'b0; v_base[i] = '0; v_len[i] = '0; v_pos[i] = '0;
         v_step[i] = '0; v_lgain[i] = 0; v_rgain[i] = 0;
      end
      for (int i = 0; i < MEM_DEPTH; i++) mix_mem[i] = '0;
      out_rate = OUTPUT_RATE_RESET;
      voice_limit = VOICES_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      rows.push_back(mk(OP_RENDER, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
      rows.push_back(mk(OP_LOAD, 0, 16'hFFFE, 8'h01, 0, 0, 0, 0, 0, 1, 0, 0));
      rows.push_back(mk(OP_LOAD, 0, 16'hFFFF, 8'hFF, 0, 0, 0, 0, 0, 1, 0, 0));
      rows.push_back(mk(OP_LOAD, 0, 0, 8'h00, 0, 0, 0, 0, 0, 1, 0, 0));
      rows.push_back(mk(OP_LOAD, 0, 1, 8'h80, 0, 0, 0, 0, 0, 1, 0, 0));
      rows.push_back(mk(OP_START, 0, 0, 0, 0, 48000, 32'h10000, 127, 0, 1, 1, 0));
      rows.push_back(mk(OP_START, 0, 0, 0, 5, 0, 32'h10000, 127, 0, 1, 1, 0));
      rows.push_back(mk(OP_START, 0, 0, 0, 5, 48000, 0, 127, 0, 1, 1, 0));
      rows.push_back(mk(OP_START, 0, 16'hFFFF, 0, 3, 48000, 32'h10000, 255, 0, 0, 0, 0));
      rows.push_back(mk(OP_START, 1, 16'hFFFF, 0, 17'h1FFFF, 20'hFFFFF, 32'hFFFFFFFF,
                        255, 9'h1FF, 0, 0, 0));
      rows.push_back(mk(OP_START, 2, 0, 0, 2, 1, 1, 64, 127, 0, 0, 0));
      rows.push_back(mk(OP_RENDER, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      rows.push_back(mk(OP_PAN, 1, 0, 0, 0, 0, 0, 0, 254, 0, 0, 0));
      rows.push_back(mk(OP_RENDER, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      rows.push_back(mk(OP_RENDER, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      rows.push_back(mk(OP_RENDER, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      rows.push_back(mk(OP_STOP, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      rows.push_back(mk(OP_STOP, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      rows.push_back(mk(3'd5, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      rows.push_back(mk(3'd7, 15, 16'hFFFF, 8'hFF, 17'h1FFFF, 20'hFFFFF, 32'hFFFFFFFF,
                        255, 9'h1FF, 0, 0, 0));
      rows.push_back(mk(OP_STOP, 15, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      foreach (rows[k]) begin
         send_request(rows[k].r);
         if (rows[k].typed && frames_due[$] != rows[k].e) begin
            $display("%0t: row %0d predictor disagrees with typed value", $time, k);
            errors++;
         end
      end
      drain();

      // few voices, invalid index
      write_csr(CSR_VOICES, 5'd1);
      rows.delete();
      rows.push_back(mk(OP_PAN, 1, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0));
      rows.push_back(mk(OP_STOP, 15, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0));
      rows.push_back(mk(OP_START, 3, 0, 0, 5, 48000, 32'h10000, 127, 0, 1, 1, 0));
      foreach (rows[k]) begin
         send_request(rows[k].r);
         if (rows[k].typed && frames_due[$] != rows[k].e) begin
            $display("%0t: row %0d predictor disagrees with typed value", $time, k);
            errors++;
         end
      end
      drain();
      write_csr(CSR_OUTPUT_RATE, 20'd0);
      write_csr(CSR_VOICES, 5'd31);
      send_request(mk(OP_START, 0, 0, 0, 5, 48000, 32'h10000, 127, 0, 0, 0, 0).r);
      drain();

      // preload a sample window so voices read only written memory
      write_csr(CSR_OUTPUT_RATE, 20'hFFFFF);
      for (int a = 0; a < 320; a++) begin
         r = '0; r.op = OP_LOAD; r.address = 16'(a); r.sample_byte = 8'($urandom);
         send_request(r);
      end

      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin send_idle_pct = 75; recv_idle_pct = 19; end
         if (phase == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
         drain();
         write_csr(CSR_OUTPUT_RATE, phase == 0 ? 20'd1 : 20'($urandom_range(8000, 96000)));
         write_csr(CSR_VOICES, phase == 2 ? 5'd16 : 5'($urandom_range(1, 16)));
         if (phase == 1) begin
            recv_hold = 1'b1;
            fork
               begin
                  guard = 0;
                  while (guard < 400) begin @(posedge clock); guard++; end
                  recv_hold = 1'b0;
               end
            join_none
         end
         for (int n = 0; n < 150; n++) begin
            case ($urandom_range(9))
               0, 1: r = start_req($urandom_range(15));
               2, 3, 4, 5: begin r = '0; r.op = OP_RENDER; end
               6: begin
                  r = start_req($urandom_range(15));
                  r.op = $urandom_range(1) ? OP_PAN : OP_STOP;
               end
               7: begin
                  r = rand_req();
                  r.address = 16'($urandom_range(320, 65535)); r.op = OP_LOAD;
               end
               default: begin
                  r = rand_req();
                  // keep any start within the written window
                  if (r.op == OP_START || r.op == OP_LOAD)
                     r.address = 16'($urandom_range(255));
                  if (r.op == OP_LOAD) r.op = OP_PAN;
                  if (r.op == OP_START) r.length = 17'($urandom_range(64));
               end
            endcase
            send_request(r);
         end
      end
      drain();

      $display("%0d requests sent, %0d responses checked, %0d renders.",
               accepted, responses, renders);
      if (errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end
endmodule
